[sv/pgm_ascii_stream_parser_core_defines.svh]
// Assertion macros shared by the graymap parser modules.
`ifndef PGM_ASCII_STREAM_PARSER_CORE_DEFINES_SVH
`define PGM_ASCII_STREAM_PARSER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PGM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pgm: same-cycle check failed");
`define PGM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pgm: next-cycle check failed");
`else
`define PGM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define PGM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/pgm_pkg.sv]
// Types and constants shared by the graymap parser modules.
`timescale 1ns / 1ps
package pgm_pkg;

	localparam int MAX_DIM_DEF    = 4096;
	localparam int VALUE_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 4;

	localparam int KIND_W      = 3;
	localparam int OUT_POS_W   = 12;
	localparam int OUT_VALUE_W = 16;

	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;

	typedef enum logic [KIND_W-1:0] {
		KIND_WIDTH  = 3'd0,
		KIND_HEIGHT = 3'd1,
		KIND_MAXVAL = 3'd2,
		KIND_PIXEL  = 3'd3,
		KIND_END    = 3'd4
	} kind_t;

	// Classified byte handed from the front to the back
	typedef struct packed {
		logic       is_ws;
		logic       is_digit;
		logic [3:0] digit;
		logic       eof;
	} class_t;

	typedef struct packed {
		kind_t                  kind;
		logic [OUT_POS_W-1:0]   row;
		logic [OUT_POS_W-1:0]   col;
		logic [OUT_VALUE_W-1:0] value;
		logic                   err;
		logic                   done;
	} res_t;

endpackage

[sv/pgm_ascii_stream_parser_core.sv]
// Top level of the ASCII graymap stream parser.
`timescale 1ns / 1ps
// Reads the text of an ASCII graymap one byte per transfer and returns the
// width, height and maximum value tokens and then each pixel with its row and
// column, in raster order; pixels beyond width times height are dropped, and
// the byte flagged end_of_file always yields a result with file_done set,
// after which the parser is back in its reset state for the next file. Both
// sides are queues: a byte is taken when push is high and full low, a result
// leaves when pop is high and empty low. One byte is taken every cycle in
// steady state while the result queue has room; the figure is set by the
// decimal accumulate and raster counter update in the back end, which
// handles one byte per cycle unless the result queue is full. The byte of a
// result waits in the classification queue, and the back end writes the
// result straight into the result queue, stalling while that queue is full.
module pgm_ascii_stream_parser_core import pgm_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             in_byte,
	input  logic                   end_of_file,
	output logic                   empty,
	input  logic                   pop,
	output logic [KIND_W-1:0]      item_kind,
	output logic [OUT_POS_W-1:0]   pixel_row,
	output logic [OUT_POS_W-1:0]   pixel_col,
	output logic [OUT_VALUE_W-1:0] token_value,
	output logic                   parse_error,
	output logic                   file_done
);

	class_t cls;
	logic   cls_valid;
	logic   cls_take;
	logic   res_full;
	logic   res_push;
	res_t   res_in;
	logic [$bits(res_t)-1:0] res_rdata;
	res_t   res_out;

	pgm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_byte     (in_byte),
		.end_of_file (end_of_file),
		.cls_take    (cls_take),
		.cls_valid   (cls_valid),
		.cls         (cls)
	);

	pgm_back #(
		.MAX_DIM    (MAX_DIM),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (cls_valid),
		.cls       (cls),
		.cls_take  (cls_take),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	pgm_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_in),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_rdata)
	);

	assign res_out     = res_t'(res_rdata);
	assign item_kind   = res_out.kind;
	assign pixel_row   = res_out.row;
	assign pixel_col   = res_out.col;
	assign token_value = res_out.value;
	assign parse_error = res_out.err;
	assign file_done   = res_out.done;

endmodule

[sv/pgm_fifo.sv]
// Small synchronous queue with push/full and pop/empty sides.
`timescale 1ns / 1ps
`include "pgm_ascii_stream_parser_core_defines.svh"
module pgm_fifo import pgm_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PGM_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`PGM_ASSERT_NEXT(a_full_hold, clk, arst_n, full && !pop, full)
	`PGM_ASSERT_NEXT(a_empty_hold, clk, arst_n, empty && !push, empty)

endmodule

[sv/pgm_front.sv]
// Front end: takes bytes, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module pgm_front import pgm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       end_of_file,
	input  logic       cls_take,
	output logic       cls_valid,
	output class_t     cls
);

	class_t           cls_in;
	logic             q_empty;
	logic [$bits(class_t)-1:0] q_rdata;

	always_comb begin
		cls_in.is_ws    = (in_byte == CHAR_SPACE) ||
		                  (in_byte >= CHAR_TAB && in_byte <= CHAR_CR);
		cls_in.is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
		cls_in.digit    = 4'(in_byte - CHAR_ZERO);
		cls_in.eof      = end_of_file;
	end

	pgm_fifo #(
		.WIDTH ($bits(class_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_class_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (cls_in),
		.pop    (cls_take),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	assign cls_valid = !q_empty;
	assign cls       = class_t'(q_rdata);

endmodule

[sv/pgm_back.sv]
// Back end: token accumulation, header fields, raster counters and result build.
`timescale 1ns / 1ps
`include "pgm_ascii_stream_parser_core_defines.svh"
module pgm_back import pgm_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cls_valid,
	input  class_t cls,
	output logic   cls_take,
	input  logic   res_full,
	output logic   res_push,
	output res_t   res
);

	localparam int VB   = VALUE_BITS;
	localparam int DW   = $clog2(MAX_DIM + 1);
	localparam int PW   = VB + 4;
	localparam int CMPW = (VB > DW) ? VB : DW;
	localparam logic [VB-1:0] VAL_LIMIT = '1;

	typedef enum logic [2:0] {
		TOK_MAGIC  = 3'd0,
		TOK_WIDTH  = 3'd1,
		TOK_HEIGHT = 3'd2,
		TOK_MAXVAL = 3'd3,
		TOK_PIXEL  = 3'd4
	} tok_t;

	tok_t          tok_q,    tok_d;
	logic          inside_q, inside_d;
	logic          stop_q,   stop_d;
	logic [VB-1:0] acc_q,    acc_d;
	logic [DW-1:0] width_q,  width_d;
	logic [DW-1:0] height_q, height_d;
	logic [DW-1:0] row_q,    row_d;
	logic [DW-1:0] col_q,    col_d;
	logic          err_q,    err_d;

	logic          starting;
	logic          complete;
	logic          emit;
	logic [PW-1:0] prod;
	logic [CMPW-1:0] v_ext;
	logic [DW-1:0] v_clamp;
	logic [DW:0]   col_inc;

	assign cls_take = cls_valid && !res_full;

	always_comb begin
		tok_d    = tok_q;
		inside_d = inside_q;
		stop_d   = stop_q;
		acc_d    = acc_q;
		width_d  = width_q;
		height_d = height_q;
		row_d    = row_q;
		col_d    = col_q;
		err_d    = err_q;
		emit     = 1'b0;

		res.kind  = KIND_END;
		res.row   = '0;
		res.col   = '0;
		res.value = '0;
		res.err   = 1'b0;
		res.done  = cls.eof;

		// Open a fresh token on its first non-whitespace byte
		starting = !cls.is_ws && !inside_q;
		if (starting) begin
			acc_d  = '0;
			stop_d = 1'b0;
		end

		prod = (PW'(acc_d) << 3) + (PW'(acc_d) << 1) + PW'(cls.digit);

		if (!cls.is_ws && !stop_d) begin
			if (cls.is_digit) begin
				if (prod > PW'(VAL_LIMIT)) begin
					acc_d = VAL_LIMIT;
					if (tok_q != TOK_MAGIC) err_d = 1'b1;
				end else begin
					acc_d = VB'(prod);
				end
			end else begin
				// Ignore later digits, keep the value so far
				stop_d = 1'b1;
				if (tok_q != TOK_MAGIC) err_d = 1'b1;
			end
		end

		inside_d = inside_q || !cls.is_ws;
		complete = inside_d && (cls.is_ws || cls.eof);

		v_ext   = CMPW'(acc_d);
		v_clamp = (v_ext > CMPW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(v_ext);
		col_inc = {1'b0, col_q} + 1'b1;

		if (complete) begin
			inside_d  = 1'b0;
			res.value = OUT_VALUE_W'(acc_d);
			unique case (tok_q)
				TOK_MAGIC: begin
					tok_d = TOK_WIDTH;
				end
				TOK_WIDTH: begin
					width_d = v_clamp;
					if (acc_d == '0) err_d = 1'b1;
					res.kind = KIND_WIDTH;
					emit     = 1'b1;
					tok_d    = TOK_HEIGHT;
				end
				TOK_HEIGHT: begin
					height_d = v_clamp;
					res.kind = KIND_HEIGHT;
					emit     = 1'b1;
					tok_d    = TOK_MAXVAL;
				end
				TOK_MAXVAL: begin
					res.kind = KIND_MAXVAL;
					emit     = 1'b1;
					tok_d    = TOK_PIXEL;
				end
				TOK_PIXEL: begin
					// Drop surplus pixels and every pixel of a zero-width image
					if (width_q != '0 && row_q < height_q) begin
						res.kind = KIND_PIXEL;
						res.row  = OUT_POS_W'(row_q);
						res.col  = OUT_POS_W'(col_q);
						emit     = 1'b1;
						if (col_inc >= {1'b0, width_q}) begin
							col_d = '0;
							row_d = row_q + 1'b1;
						end else begin
							col_d = DW'(col_inc);
						end
					end
				end
				default: begin
					tok_d = TOK_PIXEL;
				end
			endcase
		end

		res.err = err_d;
		if (!emit) res.value = '0;

		if (cls.eof) begin
			emit = 1'b1;
			tok_d    = TOK_MAGIC;
			inside_d = 1'b0;
			stop_d   = 1'b0;
			acc_d    = '0;
			width_d  = '0;
			height_d = '0;
			row_d    = '0;
			col_d    = '0;
			err_d    = 1'b0;
		end
	end

	assign res_push = cls_take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q    <= TOK_MAGIC;
			inside_q <= 1'b0;
			stop_q   <= 1'b0;
			acc_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			row_q    <= '0;
			col_q    <= '0;
			err_q    <= 1'b0;
		end else if (cls_take) begin
			tok_q    <= tok_d;
			inside_q <= inside_d;
			stop_q   <= stop_d;
			acc_q    <= acc_d;
			width_q  <= width_d;
			height_q <= height_d;
			row_q    <= row_d;
			col_q    <= col_d;
			err_q    <= err_d;
		end
	end

	`PGM_ASSERT_IMPLY(a_pixel_in_frame, clk, arst_n, res_push && res.kind == KIND_PIXEL, row_q < height_q && width_q != '0)
	`PGM_ASSERT_NEXT(a_done_resets, clk, arst_n, res_push && res.done, tok_q == TOK_MAGIC && !err_q && !inside_q)
	`PGM_ASSERT_NEXT(a_err_sticky, clk, arst_n, err_q && !(cls_take && cls.eof), err_q)

endmodule
